/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the window energy tracker.
// Every macro samples on the rising edge of clk and is masked while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hw/rtl/swre_pkg.sv */
// Package for the sliding window RF energy tracker: sizes, queue entry type,
// state encoding and saturating helpers. No dependencies.
package swre_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int ENERGY_W = 64;
  localparam int DUR_W    = 24;
  localparam int TIME_W   = 40;
  localparam int WLEN_W   = 32;
  localparam int AMP_W    = 16;
  localparam int UNIT_W   = 32;
  localparam int SCALE_W  = 2 * AMP_W;

  // APB register map
  localparam int                ADDR_W             = 2;
  localparam logic [ADDR_W-1:0] ADDR_WINDOW_LENGTH = 2'd0;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [DUR_W-1:0]    duration;
  } qentry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_PRODUCT,
    ST_OVF_POP,
    ST_ACCUM,
    ST_POP_WAIT,
    ST_POP,
    ST_RESULT
  } state_t;

  // Advance a queue pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [ENERGY_W-1:0] sat_add_energy(input logic [ENERGY_W-1:0] a,
                                                         input logic [ENERGY_W-1:0] b);
    logic [ENERGY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ENERGY_W] ? '1 : s[ENERGY_W-1:0];
  endfunction

  function automatic logic [ENERGY_W-1:0] sat_sub_energy(input logic [ENERGY_W-1:0] a,
                                                         input logic [ENERGY_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [TIME_W-1:0] sat_sub_time(input logic [TIME_W-1:0] a,
                                                     input logic [DUR_W-1:0]  b);
    logic [TIME_W-1:0] bw;
    bw = {{(TIME_W - DUR_W){1'b0}}, b};
    return (a > bw) ? a - bw : '0;
  endfunction

endpackage

/* hw/rtl/sliding_window_rf_energy.sv */
// Sliding window RF energy tracker: one sequence block per input item, one
// result item on the block marked last. Depends on swre_pkg and assert_macros.svh.
//
// Usage: an item is taken in the idle state and then squared, then multiplied
// into block energy and peak power (two 32x32 products), then accumulated and,
// with a nonzero window_length, pushed. In that mode an eviction check state
// is added, an overflow pop state when the queue is full on arrival, and a pop
// state plus another check per evicted entry, since every eviction reads the
// oldest entry from the registered read port of the queue memory. A last block
// then loads the output register in a result state, and waits there while an
// earlier result is still not taken. The queue holds QUEUE_DEPTH entries of
// energy and duration; it needs no clearing pass after reset since the fill
// count guards every read. window_length is written over APB at address 0 and
// is meant to be written only while the block is idle.
`include "assert_macros.svh"

module sliding_window_rf_energy (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swre_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // block items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                first_block,
  input  logic                                last_block,
  input  logic [swre_pkg::DUR_W-1:0]          block_duration,
  input  logic                                has_rf,
  input  logic [swre_pkg::AMP_W-1:0]          rf_amplitude,
  input  logic [swre_pkg::UNIT_W-1:0]         unit_energy,
  input  logic [swre_pkg::UNIT_W-1:0]         unit_peak,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swre_pkg::ENERGY_W-1:0]       energy_result,
  output logic [swre_pkg::ENERGY_W-1:0]       max_power,
  output logic [swre_pkg::TIME_W-1:0]         total_duration,
  output logic                                window_overflow
);

  swre_pkg::state_t state, state_next;

  // configuration
  logic [swre_pkg::WLEN_W-1:0] window_length;
  logic                        windowed;

  // captured item
  logic                          cur_first;
  logic                          cur_last;
  logic [swre_pkg::DUR_W-1:0]    cur_dur;
  logic                          cur_rf;
  logic [swre_pkg::AMP_W-1:0]    cur_amp;
  logic [swre_pkg::UNIT_W-1:0]   cur_ue;
  logic [swre_pkg::UNIT_W-1:0]   cur_up;

  // products
  logic [swre_pkg::SCALE_W-1:0]  scale;
  logic [swre_pkg::ENERGY_W-1:0] blk_energy;
  logic [swre_pkg::ENERGY_W-1:0] blk_power;

  // window state
  logic [swre_pkg::PTR_W-1:0]    head;
  logic [swre_pkg::PTR_W-1:0]    tail;
  logic [swre_pkg::COUNT_W-1:0]  count;
  logic [swre_pkg::ENERGY_W-1:0] running_energy;
  logic [swre_pkg::TIME_W-1:0]   window_time;
  logic [swre_pkg::ENERGY_W-1:0] energy_peak;
  logic [swre_pkg::ENERGY_W-1:0] power_peak;
  logic [swre_pkg::TIME_W-1:0]   duration_sum;
  logic                          overflow_seen;

  // queue memory
  swre_pkg::qentry_t queue_mem [swre_pkg::QUEUE_DEPTH];
  swre_pkg::qentry_t rd_q;
  swre_pkg::qentry_t wr_data;

  // decoded controls
  logic cfg_write;
  logic accept;
  logic mem_we;
  logic res_load;
  logic queue_full;
  logic need_pop;

  // intermediate sums
  logic [swre_pkg::TIME_W:0]     dsum_wide;
  logic [swre_pkg::TIME_W-1:0]   dsum_base;
  logic [swre_pkg::ENERGY_W-1:0] run_added;

  assign windowed   = (window_length != '0);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign queue_full = (count == swre_pkg::COUNT_W'(swre_pkg::QUEUE_DEPTH));
  assign need_pop   = (window_time > {{(swre_pkg::TIME_W - swre_pkg::WLEN_W){1'b0}},
                                      window_length}) && (count != '0);
  assign pready     = 1'b1;
  assign prdata     = (paddr == swre_pkg::ADDR_WINDOW_LENGTH) ? window_length : '0;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= '0;
    end else if (cfg_write && (paddr == swre_pkg::ADDR_WINDOW_LENGTH)) begin
      window_length <= pwdata;
    end
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swre_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      swre_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = swre_pkg::ST_SQUARE;
        end
      end
      swre_pkg::ST_SQUARE: begin
        state_next = swre_pkg::ST_PRODUCT;
      end
      swre_pkg::ST_PRODUCT: begin
        if (windowed && queue_full) begin
          state_next = swre_pkg::ST_OVF_POP;
        end else begin
          state_next = swre_pkg::ST_ACCUM;
        end
      end
      swre_pkg::ST_OVF_POP: begin
        state_next = swre_pkg::ST_ACCUM;
      end
      swre_pkg::ST_ACCUM: begin
        if (windowed) begin
          state_next = swre_pkg::ST_POP_WAIT;
        end else if (cur_last) begin
          state_next = swre_pkg::ST_RESULT;
        end else begin
          state_next = swre_pkg::ST_IDLE;
        end
      end
      swre_pkg::ST_POP_WAIT: begin
        if (need_pop) begin
          state_next = swre_pkg::ST_POP;
        end else if (cur_last) begin
          state_next = swre_pkg::ST_RESULT;
        end else begin
          state_next = swre_pkg::ST_IDLE;
        end
      end
      swre_pkg::ST_POP: begin
        state_next = swre_pkg::ST_POP_WAIT;
      end
      swre_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = swre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swre_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    res_load = 1'b0;
    case (state)
      swre_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      swre_pkg::ST_ACCUM: begin
        mem_we = windowed;
      end
      swre_pkg::ST_RESULT: begin
        res_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  // Capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_first <= first_block;
      cur_last  <= last_block;
      cur_dur   <= block_duration;
      cur_rf    <= has_rf;
      cur_amp   <= rf_amplitude;
      cur_ue    <= unit_energy;
      cur_up    <= unit_peak;
    end
  end

  // Square the amplitude, then form block energy and peak power
  always_ff @(posedge clk) begin
    if (state == swre_pkg::ST_SQUARE) begin
      scale <= {{swre_pkg::AMP_W{1'b0}}, cur_amp} * {{swre_pkg::AMP_W{1'b0}}, cur_amp};
    end
    if (state == swre_pkg::ST_PRODUCT) begin
      blk_energy <= cur_rf ? {{swre_pkg::UNIT_W{1'b0}}, scale} *
                             {{swre_pkg::SCALE_W{1'b0}}, cur_ue} : '0;
      blk_power  <= {{swre_pkg::UNIT_W{1'b0}}, scale} * {{swre_pkg::SCALE_W{1'b0}}, cur_up};
    end
  end

  // Queue memory: write the pushed block, read the oldest every cycle
  assign wr_data.energy   = blk_energy;
  assign wr_data.duration = cur_dur;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= queue_mem[head];
  end

  assign dsum_base = cur_first ? '0 : duration_sum;
  assign dsum_wide = {1'b0, dsum_base} +
                     {{(swre_pkg::TIME_W + 1 - swre_pkg::DUR_W){1'b0}}, cur_dur};
  assign run_added = swre_pkg::sat_add_energy(running_energy, blk_energy);

  // Update the window state
  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      tail           <= '0;
      count          <= '0;
      running_energy <= '0;
      window_time    <= '0;
      energy_peak    <= '0;
      power_peak     <= '0;
      duration_sum   <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      case (state)
        swre_pkg::ST_SQUARE: begin
          // clear on a first block, then add the duration
          if (cur_first) begin
            head           <= '0;
            tail           <= '0;
            count          <= '0;
            running_energy <= '0;
            window_time    <= '0;
            energy_peak    <= '0;
            power_peak     <= '0;
            overflow_seen  <= 1'b0;
          end
          duration_sum <= dsum_wide[swre_pkg::TIME_W] ? '1 : dsum_wide[swre_pkg::TIME_W-1:0];
        end
        swre_pkg::ST_OVF_POP, swre_pkg::ST_POP: begin
          // drop the oldest entry
          if (state == swre_pkg::ST_OVF_POP) begin
            overflow_seen <= 1'b1;
          end
          head  <= swre_pkg::ptr_inc(head);
          count <= count - 1'b1;
          if (count == swre_pkg::COUNT_W'(1)) begin
            running_energy <= '0;
            window_time    <= '0;
          end else begin
            running_energy <= swre_pkg::sat_sub_energy(running_energy, rd_q.energy);
            window_time    <= swre_pkg::sat_sub_time(window_time, rd_q.duration);
          end
        end
        swre_pkg::ST_ACCUM: begin
          // add the RF energy, track peaks, push the block when windowed
          if (cur_rf) begin
            running_energy <= run_added;
            if (blk_power > power_peak) begin
              power_peak <= blk_power;
            end
            if (windowed && (run_added > energy_peak)) begin
              energy_peak <= run_added;
            end
          end
          if (windowed) begin
            tail        <= swre_pkg::ptr_inc(tail);
            count       <= count + 1'b1;
            window_time <= window_time +
                           {{(swre_pkg::TIME_W - swre_pkg::DUR_W){1'b0}}, cur_dur};
          end
        end
        default: begin
          head <= head;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      energy_result   <= windowed ? energy_peak : running_energy;
      max_power       <= power_peak;
      total_duration  <= duration_sum;
      window_overflow <= overflow_seen;
    end
  end

  `ASSERT_NEVER(a_count_in_range, count > swre_pkg::COUNT_W'(swre_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `ASSERT_CLK(a_empty_time_zero, (count == '0) |-> (window_time == '0), "empty window with nonzero time")
  `ASSERT_CLK(a_pop_nonempty, (state == swre_pkg::ST_POP || state == swre_pkg::ST_OVF_POP) |-> (count != '0), "pop from empty queue")
  `ASSERT_CLK(a_accept_starts, accept |=> (state == swre_pkg::ST_SQUARE), "accepted item not started")

endmodule
